### rtl/rbnt_pkg.sv
// Shared types and constants for the receive bitmap NACK tracker.
package rbnt_pkg;

  localparam int unsigned MAX_PACKETS = 64;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned SEQ_OUT_W = 6;
  localparam int unsigned GROUP_W  = 6;
  localparam int unsigned ECHO_CNT_W = 7;
  localparam int unsigned SPN_W    = 7;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic [APB_AW-1:0] REG_SEQS_PER_NACK = 3'd0;
  localparam logic [SPN_W-1:0] SPN_RESET = 7'd16;

  localparam logic [ACTION_W-1:0] ACT_START = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DATA  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FIN   = 2'd2;

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_MISS = 1'b1;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [WORD_W-1:0]   seq;
    logic [WORD_W-1:0]   packet_count;
    logic [WORD_W-1:0]   round;
  } in_word_t;

  typedef struct packed {
    logic                  kind;
    logic [SEQ_OUT_W-1:0]  missing_seq;
    logic [GROUP_W-1:0]    nack_group;
    logic [WORD_W-1:0]     echo_round;
    logic [ECHO_CNT_W-1:0] echo_count;
    logic                  last;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic do_start;
    logic do_data;
    logic do_fin;
    logic load_ack;
    logic scan_init;
    logic scan_step;
    logic load_miss;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fin_ok;
    logic all_rcvd;
    logic bit_missing;
    logic is_last;
  } status_t;

endpackage

### rtl/rbnt_ctrl.sv
// Controller: input/output handshake and the bitmap scan sequencer.
module rbnt_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic [rbnt_pkg::ACTION_W-1:0]      in_action_i,
  output logic                               in_stall_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  input  rbnt_pkg::status_t                  status_i,
  output rbnt_pkg::cmd_t                     cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;
  logic   in_acc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q == ST_SCAN) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o           = '0;
    cmd_o.do_start  = in_acc && (in_action_i == rbnt_pkg::ACT_START);
    cmd_o.do_data   = in_acc && (in_action_i == rbnt_pkg::ACT_DATA);
    cmd_o.do_fin    = in_acc && (in_action_i == rbnt_pkg::ACT_FIN) && status_i.fin_ok;
    cmd_o.load_ack  = cmd_o.do_fin && status_i.all_rcvd;
    cmd_o.scan_init = cmd_o.do_fin && !status_i.all_rcvd;
    cmd_o.scan_step = (state_q == ST_SCAN) && out_free;
    cmd_o.load_miss = cmd_o.scan_step && status_i.bit_missing;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_ack || cmd_o.load_miss) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.scan_init) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cmd_o.load_miss && status_i.is_last) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/rbnt_dp.sv
// Datapath: bitmap, totals, round tracking, scan counters and output register.
module rbnt_dp #(
  parameter int unsigned MAX_PACKETS = rbnt_pkg::MAX_PACKETS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rbnt_pkg::in_word_t              in_word_i,
  input  logic                            cfg_we_i,
  input  logic [rbnt_pkg::SPN_W-1:0]      cfg_wdata_i,
  output logic [rbnt_pkg::SPN_W-1:0]      cfg_spn_o,
  input  rbnt_pkg::cmd_t                  cmd_i,
  output rbnt_pkg::status_t               status_o,
  output rbnt_pkg::out_word_t             out_word_o
);

  localparam int unsigned CW = $clog2(MAX_PACKETS + 1);
  localparam int unsigned IW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;

  logic [MAX_PACKETS-1:0]           bitmap_q;
  logic [CW-1:0]                    rcv_total_q;
  logic [CW-1:0]                    exp_total_q;
  logic                             started_q;
  logic                             finished_q;
  logic [rbnt_pkg::WORD_W-1:0]      newest_q;
  logic [rbnt_pkg::WORD_W-1:0]      round_q;
  logic [rbnt_pkg::SPN_W-1:0]       spn_q;

  logic [IW-1:0]                    idx_q;
  logic [CW-1:0]                    pos_q;
  logic [CW-1:0]                    missing_q;
  logic [rbnt_pkg::GROUP_W-1:0]     grp_q;
  logic [rbnt_pkg::SPN_W-1:0]       inner_q;

  rbnt_pkg::out_word_t              out_word_q;

  logic [rbnt_pkg::SPN_W-1:0]       spn_eff;
  logic [rbnt_pkg::SPN_W-1:0]       inner_inc;
  logic [IW-1:0]                    data_idx;
  logic                             start_ok;
  logic                             data_ok;

  assign spn_eff   = (spn_q == '0) ? rbnt_pkg::SPN_W'(1) : spn_q;
  assign inner_inc = inner_q + rbnt_pkg::SPN_W'(1);
  assign data_idx  = in_word_i.seq[IW-1:0];

  assign start_ok = !started_q &&
                    (in_word_i.packet_count <= rbnt_pkg::WORD_W'(MAX_PACKETS));
  // seq below the count also keeps the index inside the bitmap
  assign data_ok  = started_q &&
                    (in_word_i.seq < rbnt_pkg::WORD_W'(exp_total_q)) &&
                    !bitmap_q[data_idx];

  assign status_o.fin_ok      = started_q && !finished_q && (in_word_i.round > newest_q);
  assign status_o.all_rcvd    = (rcv_total_q == exp_total_q);
  assign status_o.bit_missing = !bitmap_q[idx_q];
  assign status_o.is_last     = ((pos_q + CW'(1)) == missing_q);

  assign cfg_spn_o  = spn_q;
  assign out_word_o = out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bitmap_q    <= '0;
      rcv_total_q <= '0;
      exp_total_q <= '0;
      started_q   <= 1'b0;
      finished_q  <= 1'b0;
      newest_q    <= '0;
      spn_q       <= rbnt_pkg::SPN_RESET;
    end else begin
      if (cfg_we_i) begin
        spn_q <= cfg_wdata_i;
      end
      if (cmd_i.do_start && start_ok) begin
        exp_total_q <= in_word_i.packet_count[CW-1:0];
        bitmap_q    <= '0;
        rcv_total_q <= '0;
        started_q   <= 1'b1;
      end
      if (cmd_i.do_data && data_ok) begin
        bitmap_q[data_idx] <= 1'b1;
        rcv_total_q        <= rcv_total_q + CW'(1);
      end
      if (cmd_i.do_fin) begin
        newest_q <= in_word_i.round;
      end
      if (cmd_i.load_ack) begin
        finished_q <= 1'b1;
      end
    end
  end

  // scan counters and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      idx_q     <= '0;
      pos_q     <= '0;
      grp_q     <= '0;
      inner_q   <= '0;
      round_q   <= in_word_i.round;
      missing_q <= exp_total_q - rcv_total_q;
    end else if (cmd_i.scan_step) begin
      idx_q <= idx_q + IW'(1);
      if (cmd_i.load_miss) begin
        pos_q <= pos_q + CW'(1);
        if (inner_inc == spn_eff) begin
          inner_q <= '0;
          grp_q   <= grp_q + rbnt_pkg::GROUP_W'(1);
        end else begin
          inner_q <= inner_inc;
        end
      end
    end

    if (cmd_i.load_ack) begin
      out_word_q.kind        <= rbnt_pkg::KIND_ACK;
      out_word_q.missing_seq <= '0;
      out_word_q.nack_group  <= '0;
      out_word_q.echo_round  <= in_word_i.round;
      out_word_q.echo_count  <= rbnt_pkg::ECHO_CNT_W'(exp_total_q);
      out_word_q.last        <= 1'b1;
    end else if (cmd_i.load_miss) begin
      out_word_q.kind        <= rbnt_pkg::KIND_MISS;
      out_word_q.missing_seq <= rbnt_pkg::SEQ_OUT_W'(idx_q);
      out_word_q.nack_group  <= grp_q;
      out_word_q.echo_round  <= round_q;
      out_word_q.echo_count  <= rbnt_pkg::ECHO_CNT_W'(exp_total_q);
      out_word_q.last        <= status_o.is_last;
    end
  end

endmodule

### rtl/receive_bitmap_nack_tracker.sv
// Top level of the receive bitmap NACK tracker.
//
// Input channel (in_valid_i / in_stall_o / in_word_i) takes start, data and fin
// words. Start and data words cause no result; start arms the tracker and clears
// the bitmap, data marks one sequence number. A fresh fin gives either one
// completion word or one word per missing sequence number on the output channel
// (out_valid_o / out_stall_i / out_word_o), each tagged with its NACK group.
// The APB port holds seqs_per_nack at byte address 0; pready is always high.
//
// Start and data words are accepted back to back unless the input is stalled.
// A completion word is registered in the cycle after its fin. A scanning fin
// reads one bitmap bit per cycle from sequence 0 up, and the input stays stalled
// until the last missing word is loaded. The scan also waits whenever the output
// register is full and stalled, and any input word is stalled while a stalled
// result is held there.
// Reset clears the bitmap, the totals and the round, and leaves the block
// unarmed with seqs_per_nack at 16. A stalled output word holds steady.
module receive_bitmap_nack_tracker #(
  parameter int unsigned MAX_PACKETS = rbnt_pkg::MAX_PACKETS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rbnt_pkg::in_word_t            in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rbnt_pkg::out_word_t           out_word_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rbnt_pkg::APB_AW-1:0]   paddr,
  input  logic [rbnt_pkg::APB_DW-1:0]   pwdata,
  output logic [rbnt_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  rbnt_pkg::cmd_t               cmd;
  rbnt_pkg::status_t            status;
  logic                         cfg_hit;
  logic                         cfg_we;
  logic [rbnt_pkg::SPN_W-1:0]   cfg_spn;

  assign pready  = 1'b1;
  // registers sit on 4-byte boundaries; low address bits are ignored
  assign cfg_hit = (paddr[rbnt_pkg::APB_AW-1:2] == rbnt_pkg::REG_SEQS_PER_NACK[rbnt_pkg::APB_AW-1:2]);
  assign cfg_we  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? rbnt_pkg::APB_DW'(cfg_spn) : '0;

  rbnt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_word_i.action),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rbnt_dp #(
    .MAX_PACKETS (MAX_PACKETS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (pwdata[rbnt_pkg::SPN_W-1:0]),
    .cfg_spn_o   (cfg_spn),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_word_o  (out_word_o)
  );

endmodule

### rtl/rbnt_chk.sv
// Port-level checker for the receive bitmap NACK tracker, with its bind.
module rbnt_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input rbnt_pkg::out_word_t  out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("output word changed while stalled");

  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.kind == rbnt_pkg::KIND_ACK) |->
      out_word_o.last && (out_word_o.missing_seq == '0) && (out_word_o.nack_group == '0))
    else $error("completion word malformed");

  a_miss_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.kind == rbnt_pkg::KIND_MISS) |->
      (rbnt_pkg::ECHO_CNT_W'(out_word_o.missing_seq) < out_word_o.echo_count))
    else $error("missing sequence number beyond packet count");

endmodule

bind receive_bitmap_nack_tracker rbnt_chk u_rbnt_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
